@@ design/tlecl_pkg.sv @@
// Shared types, constants and helpers for the two-level exclusive cache lookup core.
package tlecl_pkg;

    // Geometry
    localparam int ADDR_W    = 48;
    localparam int STAMP_W   = 32;
    localparam int WAY_W     = 3;
    localparam int MAX_WAYS  = 8;
    localparam int L1_SET_W  = 6;
    localparam int L2_SET_W  = 8;
    localparam int L1_SETS   = 1 << L1_SET_W;
    localparam int L2_SETS   = 1 << L2_SET_W;
    localparam int L1_DEPTH  = 512;
    localparam int L2_DEPTH  = 2048;
    localparam int ENTRY_W   = ADDR_W + STAMP_W;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_L1_SET_BITS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_L1_WAYS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_L2_SET_BITS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_L2_WAYS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_L1_POLICY   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_L2_POLICY   = 3'd6;

    localparam logic [2:0] L1_SET_BITS_MAX = 3'd6;
    localparam logic [3:0] L2_SET_BITS_MAX = 4'd8;
    localparam logic [3:0] WAYS_MAX        = 4'd8;

    // Outcome codes
    localparam logic [1:0] OUT_L1_HIT = 2'd0;
    localparam logic [1:0] OUT_L2_HIT = 2'd1;
    localparam logic [1:0] OUT_MISS   = 2'd2;

    localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

    // Controller commands to the datapath
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CLEAR,
        CMD_LOAD,
        CMD_L1_RD,
        CMD_L1_CMP,
        CMD_TOUCH,
        CMD_L2_RD,
        CMD_L2_CMP,
        CMD_PLACE,
        CMD_V_RD,
        CMD_V_CMP,
        CMD_L2_WR,
        CMD_L1_WR,
        CMD_FINISH
    } cmd_t;

    // Datapath status back to the controller
    typedef struct packed {
        logic hit;
        logic last;
        logic l1_lru;
        logic l1_free;
        logic l2_free;
    } sts_t;

    // Lowest set bit of an 8-bit vector
    function automatic logic [WAY_W-1:0] find_first(input logic [MAX_WAYS-1:0] v);
        logic [WAY_W-1:0] r;
        r = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = WAY_W'(i);
            end
        end
        return r;
    endfunction

endpackage

@@ design/tlecl_ram.sv @@
// Generic single-port RAM with registered read.
module tlecl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata <= mem_reg[addr];
    end

endmodule

@@ design/tlecl_ctrl.sv @@
// Controller state machine sequencing lookups, scans and fills.
module tlecl_ctrl import tlecl_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  sts_t sts,
    output cmd_t cmd,
    output logic busy
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_L1_RD, S_L1_CMP, S_TOUCH, S_L2_RD, S_L2_CMP, S_PLACE,
        S_V_RD, S_V_CMP, S_L2_WR, S_L1_WR, S_FINISH
    } state_t;

    state_t state_reg, state_next;

    assign busy = (state_reg != S_IDLE);

    // Command decode
    always_comb
    begin
        unique case (state_reg)
            S_CLEAR:  cmd = CMD_CLEAR;
            S_IDLE:   cmd = start ? CMD_LOAD : CMD_NONE;
            S_L1_RD:  cmd = CMD_L1_RD;
            S_L1_CMP: cmd = CMD_L1_CMP;
            S_TOUCH:  cmd = CMD_TOUCH;
            S_L2_RD:  cmd = CMD_L2_RD;
            S_L2_CMP: cmd = CMD_L2_CMP;
            S_PLACE:  cmd = CMD_PLACE;
            S_V_RD:   cmd = CMD_V_RD;
            S_V_CMP:  cmd = CMD_V_CMP;
            S_L2_WR:  cmd = CMD_L2_WR;
            S_L1_WR:  cmd = CMD_L1_WR;
            S_FINISH: cmd = CMD_FINISH;
            default:  cmd = CMD_NONE;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:  if (sts.last) state_next = S_IDLE;
            S_IDLE:   if (start) state_next = S_L1_RD;
            S_L1_RD:  state_next = S_L1_CMP;
            S_L1_CMP:
            begin
                priority if (sts.hit) state_next = sts.l1_lru ? S_TOUCH : S_FINISH;
                else if (sts.last)    state_next = S_L2_RD;
            end
            S_TOUCH:  state_next = S_FINISH;
            S_L2_RD:  state_next = S_L2_CMP;
            S_L2_CMP: if (sts.hit || sts.last) state_next = S_PLACE;
            S_PLACE:  state_next = sts.l1_free ? S_L1_WR : S_V_RD;
            S_V_RD:   state_next = sts.l2_free ? S_L2_WR : S_V_CMP;
            S_V_CMP:  if (sts.last) state_next = S_L2_WR;
            S_L2_WR:  state_next = S_L1_WR;
            S_L1_WR:  state_next = S_FINISH;
            S_FINISH: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ design/tlecl_dpath.sv @@
// Datapath: configuration, tag and valid RAMs, scan registers and results.
module tlecl_dpath import tlecl_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    input  logic [ADDR_W-1:0]     address,
    input  logic                  is_write,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  done,
    output logic [1:0]            outcome,
    output logic                  memory_write,
    output logic                  victim_moved,
    output logic                  l2_line_dropped
);

    // Effective configuration (already limited to the supported range)
    logic [2:0] s1b_reg;
    logic [3:0] w1_reg, s2b_reg, w2_reg, off_reg;
    logic       pol1_reg;

    // Transaction registers
    logic [ADDR_W-1:0]   addr_reg, line_reg, vblock_reg, hit_block_reg;
    logic [L1_SET_W-1:0] set1_reg;
    logic [L2_SET_W-1:0] set2_reg, vset_reg, clr_cnt_reg;
    logic [WAY_W-1:0]    way_reg, min_way_reg, l1_pick_reg, l2_pick_reg;
    logic [STAMP_W-1:0]  min_stamp_reg, cnt_reg;
    logic                l2_free_reg, done_reg, wr_reg, moved_reg, dropped_reg;
    logic [1:0]          outcome_reg;

    // RAM ports
    logic                        l1_we, l2_we, l1v_we, l2v_we;
    logic [L1_SET_W+WAY_W-1:0]   l1_addr;
    logic [L2_SET_W+WAY_W-1:0]   l2_addr;
    logic [ENTRY_W-1:0]          l1_wdata, l2_wdata, l1_rdata, l2_rdata;
    logic [L1_SET_W-1:0]         l1v_addr;
    logic [L2_SET_W-1:0]         l2v_addr;
    logic [MAX_WAYS-1:0]         l1v_wdata, l2v_wdata, l1v_rdata, l2v_rdata;

    tlecl_ram #(.WIDTH(ENTRY_W), .DEPTH(L1_DEPTH)) u_l1_ram (
        .clk(clk), .we(l1_we), .addr(l1_addr), .wdata(l1_wdata), .rdata(l1_rdata)
    );

    tlecl_ram #(.WIDTH(ENTRY_W), .DEPTH(L2_DEPTH)) u_l2_ram (
        .clk(clk), .we(l2_we), .addr(l2_addr), .wdata(l2_wdata), .rdata(l2_rdata)
    );

    // One row of valid bits per set
    tlecl_ram #(.WIDTH(MAX_WAYS), .DEPTH(L1_SETS)) u_l1_vld_ram (
        .clk(clk), .we(l1v_we), .addr(l1v_addr), .wdata(l1v_wdata), .rdata(l1v_rdata)
    );

    tlecl_ram #(.WIDTH(MAX_WAYS), .DEPTH(L2_SETS)) u_l2_vld_ram (
        .clk(clk), .we(l2v_we), .addr(l2v_addr), .wdata(l2v_wdata), .rdata(l2v_rdata)
    );

    // Derived values
    logic [ADDR_W-1:0]   line_in, l1_rd_block, l2_rd_block;
    logic [STAMP_W-1:0]  l1_rd_stamp, l2_rd_stamp, stamp_next;
    logic [L1_SET_W-1:0] mask1;
    logic [L2_SET_W-1:0] mask2, vset;
    logic [MAX_WAYS-1:0] wmask1, wmask2, l1_free_vec, l2_free_vec;
    logic                l1_match, l2_match, last1, last2, clr_last;
    logic [WAY_W-1:0]    way_inc, l2_wr_way;

    assign line_in     = address >> off_reg;
    assign l1_rd_block = l1_rdata[ENTRY_W-1:STAMP_W];
    assign l1_rd_stamp = l1_rdata[STAMP_W-1:0];
    assign l2_rd_block = l2_rdata[ENTRY_W-1:STAMP_W];
    assign l2_rd_stamp = l2_rdata[STAMP_W-1:0];
    assign stamp_next  = (cnt_reg == STAMP_MAX) ? cnt_reg : cnt_reg + 1'b1;
    assign mask1       = L1_SET_W'((7'd1 << s1b_reg) - 7'd1);
    assign mask2       = L2_SET_W'((9'd1 << s2b_reg) - 9'd1);
    assign wmask1      = MAX_WAYS'((9'd1 << w1_reg) - 9'd1);
    assign wmask2      = MAX_WAYS'((9'd1 << w2_reg) - 9'd1);
    assign vset        = L2_SET_W'(vblock_reg >> off_reg) & mask2;
    assign l1_free_vec = ~l1v_rdata & wmask1;
    assign l2_free_vec = ~l2v_rdata & wmask2;
    assign last1       = (way_reg == WAY_W'(w1_reg - 4'd1));
    assign last2       = (way_reg == WAY_W'(w2_reg - 4'd1));
    assign clr_last    = (clr_cnt_reg == '1);
    assign way_inc     = way_reg + 1'b1;
    assign l1_match    = l1v_rdata[way_reg]
                         && ((l1_rd_block >> off_reg) == line_reg);
    assign l2_match    = l2v_rdata[way_reg]
                         && ((l2_rd_block >> off_reg) == line_reg);
    assign l2_wr_way   = l2_free_reg ? l2_pick_reg : min_way_reg;

    // Status to the controller
    always_comb
    begin
        sts.hit     = (cmd == CMD_L1_CMP) ? l1_match : l2_match;
        sts.last    = (cmd == CMD_CLEAR) ? clr_last
                    : (cmd == CMD_V_CMP || cmd == CMD_L2_CMP) ? last2 : last1;
        sts.l1_lru  = !pol1_reg;
        sts.l1_free = |l1_free_vec;
        sts.l2_free = |l2_free_vec;
    end

    // RAM port control
    always_comb
    begin
        l1_we     = 1'b0;
        l2_we     = 1'b0;
        l1v_we    = 1'b0;
        l2v_we    = 1'b0;
        l1_addr   = {set1_reg, way_reg};
        l2_addr   = {set2_reg, way_reg};
        l1_wdata  = {addr_reg, stamp_next};
        l2_wdata  = {vblock_reg, stamp_next};
        l1v_addr  = set1_reg;
        l2v_addr  = set2_reg;
        l1v_wdata = l1v_rdata | (MAX_WAYS'(1) << l1_pick_reg);
        l2v_wdata = l2v_rdata & ~(MAX_WAYS'(1) << way_reg);
        unique case (cmd)
            CMD_CLEAR:
            begin
                l1v_we    = 1'b1;
                l2v_we    = 1'b1;
                l1v_addr  = clr_cnt_reg[L1_SET_W-1:0];
                l2v_addr  = clr_cnt_reg;
                l1v_wdata = '0;
                l2v_wdata = '0;
            end
            CMD_L1_RD:  l1_addr = {set1_reg, {WAY_W{1'b0}}};
            CMD_L1_CMP: l1_addr = {set1_reg, way_inc};
            CMD_TOUCH:
            begin
                l1_we    = 1'b1;
                l1_wdata = {hit_block_reg, stamp_next};
            end
            CMD_L1_WR:
            begin
                l1_we   = 1'b1;
                l1v_we  = 1'b1;
                l1_addr = {set1_reg, l1_pick_reg};
            end
            CMD_L2_RD:  l2_addr = {set2_reg, {WAY_W{1'b0}}};
            CMD_L2_CMP:
            begin
                // an L2 hit removes the line from L2
                l2_addr = {set2_reg, way_inc};
                l2v_we  = l2_match;
            end
            CMD_PLACE:  l2v_addr = vset;
            CMD_V_RD:
            begin
                l2_addr  = {vset_reg, {WAY_W{1'b0}}};
                l2v_addr = vset_reg;
            end
            CMD_V_CMP:
            begin
                l2_addr  = {vset_reg, way_inc};
                l2v_addr = vset_reg;
            end
            CMD_L2_WR:
            begin
                l2_we     = 1'b1;
                l2v_we    = 1'b1;
                l2_addr   = {vset_reg, l2_wr_way};
                l2v_addr  = vset_reg;
                l2v_wdata = l2v_rdata | (MAX_WAYS'(1) << l2_wr_way);
            end
            default: ;
        endcase
    end

    // Control state: configuration, clearing count, stamp counter, strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1b_reg     <= '0;
            w1_reg      <= 4'd1;
            s2b_reg     <= '0;
            w2_reg      <= 4'd1;
            off_reg     <= '0;
            pol1_reg    <= 1'b0;
            cnt_reg     <= '0;
            done_reg    <= 1'b0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            done_reg <= (cmd == CMD_FINISH);
            if (cmd == CMD_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cfg_wr_en)
            begin
                // L2 policy has no effect: an L2 hit always removes the line
                case (cfg_index)
                    REG_L1_SET_BITS:
                        s1b_reg <= (cfg_data[2:0] > L1_SET_BITS_MAX) ? L1_SET_BITS_MAX
                                                                     : cfg_data[2:0];
                    REG_L1_WAYS:
                        w1_reg <= (cfg_data == 4'd0) ? 4'd1
                                : (cfg_data > WAYS_MAX) ? WAYS_MAX : cfg_data;
                    REG_L2_SET_BITS:
                        s2b_reg <= (cfg_data > L2_SET_BITS_MAX) ? L2_SET_BITS_MAX
                                                                : cfg_data;
                    REG_L2_WAYS:
                        w2_reg <= (cfg_data == 4'd0) ? 4'd1
                                : (cfg_data > WAYS_MAX) ? WAYS_MAX : cfg_data;
                    REG_OFFSET_BITS: off_reg  <= cfg_data;
                    REG_L1_POLICY:   pol1_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (cmd == CMD_TOUCH || cmd == CMD_L1_WR || cmd == CMD_L2_WR)
            begin
                cnt_reg <= stamp_next;
            end
        end
    end

    // Transaction payload registers
    always_ff @(posedge clk)
    begin
        unique case (cmd)
            CMD_LOAD:
            begin
                addr_reg    <= address;
                wr_reg      <= is_write;
                line_reg    <= line_in;
                set1_reg    <= line_in[L1_SET_W-1:0] & mask1;
                set2_reg    <= line_in[L2_SET_W-1:0] & mask2;
                way_reg     <= '0;
                outcome_reg <= OUT_MISS;
                moved_reg   <= 1'b0;
                dropped_reg <= 1'b0;
            end
            CMD_L1_CMP:
            begin
                // running minimum, strict compare keeps the lowest way on ties
                if (way_reg == '0 || l1_rd_stamp < min_stamp_reg)
                begin
                    min_stamp_reg <= l1_rd_stamp;
                    min_way_reg   <= way_reg;
                    vblock_reg    <= l1_rd_block;
                end
                if (l1_match)
                begin
                    outcome_reg   <= OUT_L1_HIT;
                    hit_block_reg <= l1_rd_block;
                end
                else
                begin
                    way_reg <= last1 ? '0 : way_inc;
                end
            end
            CMD_L2_CMP:
            begin
                if (l2_match)
                begin
                    outcome_reg <= OUT_L2_HIT;
                end
                else
                begin
                    way_reg <= way_inc;
                end
            end
            CMD_PLACE:
            begin
                l1_pick_reg <= (|l1_free_vec) ? find_first(l1_free_vec) : min_way_reg;
                vset_reg    <= vset;
                way_reg     <= '0;
            end
            CMD_V_RD:
            begin
                // valid row of the victim's L2 set is on the read port now
                l2_free_reg <= |l2_free_vec;
                l2_pick_reg <= find_first(l2_free_vec);
            end
            CMD_V_CMP:
            begin
                if (way_reg == '0 || l2_rd_stamp < min_stamp_reg)
                begin
                    min_stamp_reg <= l2_rd_stamp;
                    min_way_reg   <= way_reg;
                end
                way_reg <= way_inc;
            end
            CMD_L2_WR:
            begin
                moved_reg   <= 1'b1;
                dropped_reg <= !l2_free_reg;
            end
            default: ;
        endcase
    end

    assign done            = done_reg;
    assign outcome         = outcome_reg;
    assign memory_write    = wr_reg;
    assign victim_moved    = moved_reg;
    assign l2_line_dropped = dropped_reg;

endmodule

@@ design/two_level_exclusive_cache_lookup_core.sv @@
// Top level of the two-level exclusive cache lookup core.
//
// Usage: present address and is_write with start high while busy is low; the
// transaction is taken at that clock edge and busy rises. One result comes
// back per transaction: done pulses for exactly one cycle with outcome,
// memory_write, victim_moved and l2_line_dropped valid in that cycle. The
// receiver cannot stall; the result must be taken when done is high.
// Sequence: an L1 hit in way j is found by scanning the L1 ways in order,
// with an LRU refresh added when the L1 policy asks for it. A miss scans
// the L1 ways and then the L2 ways; a full L1 set adds a victim valid row
// read and an L2 fill, and a full L2 set adds a min scan of its w2 ways.
// The way scans run over the single read port of each tag RAM. Busy falls
// with done, so the next transaction can be taken at the edge that ends the
// done cycle; one transaction is worked at a time. Configuration: cfg_wr_en
// with cfg_index and cfg_data writes one register at a clock edge; the user
// must write only while busy is low, as the block does not enforce it.
// Index 7 is ignored. Reset (rst_n low) resets the stamp counter and the
// configuration; then a clearing pass zeroes the valid RAMs while busy stays
// high.
module two_level_exclusive_cache_lookup_core import tlecl_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [ADDR_W-1:0]     address,
    input  logic                  is_write,
    output logic                  done,
    output logic [1:0]            outcome,
    output logic                  memory_write,
    output logic                  victim_moved,
    output logic                  l2_line_dropped,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    tlecl_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .sts(sts), .cmd(cmd), .busy(busy)
    );

    tlecl_dpath u_dpath (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .address(address), .is_write(is_write),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .outcome(outcome), .memory_write(memory_write),
        .victim_moved(victim_moved), .l2_line_dropped(l2_line_dropped)
    );

endmodule
